### src/tlict_pkg.sv
// Shared types and codes of the two-level cache tag block.
package tlict_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SPLIT,
		ST_READ,
		ST_EXEC,
		ST_FIN
	} state_t;

	// One job is one read-modify-write pass over a near row and/or a far row.
	typedef enum logic [2:0] {
		J_LOOK,
		J_NINV,
		J_FMARK,
		J_FFILL,
		J_NFILL
	} job_t;

	localparam logic [1:0] HIT_L1    = 2'd0;
	localparam logic [1:0] HIT_L2    = 2'd1;
	localparam logic [1:0] MISS_BOTH = 2'd2;

	localparam logic OP_WRITE = 1'b1;

endpackage

### src/tlict_req_if.sv
// Request channel: one read or write access.
interface tlict_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] address;
	logic        end_of_trace;

	modport source (output valid, output operation, output address, output end_of_trace,
		input ready);
	modport sink (input valid, input operation, input address, input end_of_trace,
		output ready);
endinterface

### src/tlict_rsp_if.sv
// Response channel: outcome of one access.
interface tlict_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] hit_level;
	logic [1:0] l1_writebacks;
	logic       l2_marked_dirty;
	logic       l2_writeback;
	logic       trace_done;

	modport source (output valid, output hit_level, output l1_writebacks,
		output l2_marked_dirty, output l2_writeback, output trace_done, input ready);
	modport sink (input valid, input hit_level, input l1_writebacks,
		input l2_marked_dirty, input l2_writeback, input trace_done, output ready);
endinterface

### src/tlict_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlict_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### src/two_level_inclusive_cache_tags.sv
// Tag, state and LRU controller of a two-level inclusive write-back cache.
//
// Usage: one access (operation, address, end_of_trace) is taken on req when
// valid and ready are high; one response (hit_level, l1_writebacks,
// l2_marked_dirty, l2_writeback, trace_done) is offered on rsp for each.
// Each level keeps one RAM row per set holding all ways (tag, valid, dirty,
// recency rank). Work is a chain of row passes; each pass is split (set
// index), read, execute and write back.
// An L1 hit takes one pass, an L2 hit two or three, a miss in both up to
// six (lookup, L1 invalidate, L2 mark, L2 fill, L1 fill, L2 mark);
// the next request is taken the cycle after the response is registered.
// If either set count is not a power of two, both set indices come from a
// reciprocal multiply whose quotient is registered before the remainder is
// formed, which lengthens every split.
// Only one access is worked on at a time; req.ready is high while idle.
// Reset: a clearing pass writes zero rows into both RAMs, one row per cycle,
// up to row max(NEAR_SETS, FAR_SETS) - 1, during which no request is taken.
// A stalled rsp holds its response; the next request may already be taken
// and worked on, and its response waits until the output register frees.
module two_level_inclusive_cache_tags
	import tlict_pkg::*;
#(
	parameter int OFFSET_BITS = 6,
	parameter int NEAR_SETS   = 64,
	parameter int NEAR_WAYS   = 4,
	parameter int FAR_SETS    = 512,
	parameter int FAR_WAYS    = 8,
	parameter int ADDR_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	tlict_req_if.sink   req,
	tlict_rsp_if.source rsp
);
	// address width is ADDR_BITS, capped at 33 bits
	localparam int AW   = ADDR_BITS < 33 ? ADDR_BITS : 33;
	localparam int QW   = AW - OFFSET_BITS;
	localparam int NLG  = $clog2(NEAR_SETS + 1) - 1;
	localparam int FLG  = $clog2(FAR_SETS + 1) - 1;
	localparam int NSH  = OFFSET_BITS + NLG;
	localparam int FSH  = OFFSET_BITS + FLG;
	localparam int NTW  = AW > NSH ? AW - NSH : 1;
	localparam int FTW  = AW > FSH ? AW - FSH : 1;
	localparam int NSW  = NEAR_SETS > 1 ? $clog2(NEAR_SETS) : 1;
	localparam int FSW  = FAR_SETS > 1 ? $clog2(FAR_SETS) : 1;
	localparam int NWW  = NEAR_WAYS > 1 ? $clog2(NEAR_WAYS) : 1;
	localparam int FWW  = FAR_WAYS > 1 ? $clog2(FAR_WAYS) : 1;
	localparam int NEW  = NTW + NWW + 2;
	localparam int FEW  = FTW + FWW + 2;
	localparam int NROW = NEAR_WAYS * NEW;
	localparam int FROW = FAR_WAYS * FEW;
	localparam bit POW2 = ((NEAR_SETS & (NEAR_SETS - 1)) == 0) &&
		((FAR_SETS & (FAR_SETS - 1)) == 0);
	localparam int MAXS = NEAR_SETS > FAR_SETS ? NEAR_SETS : FAR_SETS;
	localparam int CLW  = MAXS > 1 ? $clog2(MAXS) : 1;
	// reciprocal constants: quotient = (q * MUL) >> (QW + ceil(log2(sets)))
	localparam int NL   = $clog2(NEAR_SETS);
	localparam int FL   = $clog2(FAR_SETS);
	localparam int MW   = QW + 1;
	localparam int PW   = QW + MW;
	localparam logic [MW-1:0] NMUL = MW'(((longint'(1) << (QW + NL)) +
		longint'(NEAR_SETS) - 1) / longint'(NEAR_SETS));
	localparam logic [MW-1:0] FMUL = MW'(((longint'(1) << (QW + FL)) +
		longint'(FAR_SETS) - 1) / longint'(FAR_SETS));

	typedef logic [NEAR_WAYS-1:0][NWW-1:0] nrank_t;
	typedef logic [FAR_WAYS-1:0][FWW-1:0]  frank_t;

	// Control state.
	state_t         state_q, state_d;
	job_t           job_q, job_d;
	logic           ret_fill_q, ret_fill_d;   // after FMARK: 1 go on to far fill
	logic [CLW-1:0] clr_q, clr_d;
	logic           cnt_q, cnt_d;             // set once the split pass has registered its reciprocal quotient
	logic           out_valid_q, out_valid_d;

	// Access context.
	logic           op_q, op_d;
	logic           eot_q, eot_d;
	logic [AW-1:0]  a_q, a_d;
	logic [AW-1:0]  jaddr_q, jaddr_d;         // address the current pass works on
	logic [QW-1:0]  nquo_s1, fquo_s1;
	logic [NSW-1:0] ns_q, ns_d;
	logic [FSW-1:0] fs_q, fs_d;
	logic [1:0]     level_q, level_d;
	logic [1:0]     wb_q, wb_d;
	logic           marked_q, marked_d;
	logic           l2wb_q, l2wb_d;
	logic [FWW-1:0] fvict_q, fvict_d;

	// Response register.
	logic [1:0]     o_level_q, o_level_d;
	logic [1:0]     o_wb_q, o_wb_d;
	logic           o_marked_q, o_marked_d;
	logic           o_l2wb_q, o_l2wb_d;
	logic           o_eot_q, o_eot_d;

	// RAM ports.
	logic            n_we, n_re, f_we, f_re;
	logic [NSW-1:0]  n_waddr;
	logic [FSW-1:0]  f_waddr;
	logic [NROW-1:0] n_rdata, n_wdata;
	logic [FROW-1:0] f_rdata, f_wdata;

	// Unpacked rows as read and as written back.
	logic [NEAR_WAYS-1:0][NTW-1:0] nt_r, nt_w;
	nrank_t                        nr_r, nr_w;
	logic [NEAR_WAYS-1:0]          nv_r, nv_w, nd_r, nd_w;
	logic [FAR_WAYS-1:0][FTW-1:0]  ft_r, ft_w;
	frank_t                        fr_r, fr_w;
	logic [FAR_WAYS-1:0]           fv_r, fv_w, fd_r, fd_w;

	logic [NTW-1:0] n_tag;
	logic [FTW-1:0] f_tag;
	logic [QW-1:0]  q;
	logic [PW-1:0]  n_prod, f_prod;
	logic [QW-1:0]  n_rem, f_rem;
	logic           nhit, fhit;
	logic [NWW-1:0] nway, npick;
	logic [FWW-1:0] fway, fpick;

	function automatic nrank_t n_touch(input nrank_t rk, input logic [NEAR_WAYS-1:0] vl,
		input logic [NWW-1:0] w);
		nrank_t o;
		o = rk;
		for (int v = 0; v < NEAR_WAYS; v++) begin
			if (NWW'(v) != w && vl[v] && (!vl[w] || rk[v] < rk[w])) begin
				o[v] = rk[v] + 1'b1;
			end
		end
		o[w] = '0;
		return o;
	endfunction

	function automatic frank_t f_touch(input frank_t rk, input logic [FAR_WAYS-1:0] vl,
		input logic [FWW-1:0] w);
		frank_t o;
		o = rk;
		for (int v = 0; v < FAR_WAYS; v++) begin
			if (FWW'(v) != w && vl[v] && (!vl[w] || rk[v] < rk[w])) begin
				o[v] = rk[v] + 1'b1;
			end
		end
		o[w] = '0;
		return o;
	endfunction

	// removing a line closes the gap above its rank
	function automatic nrank_t n_close(input nrank_t rk, input logic [NEAR_WAYS-1:0] vl,
		input logic [NWW-1:0] w);
		nrank_t o;
		o = rk;
		for (int v = 0; v < NEAR_WAYS; v++) begin
			if (NWW'(v) != w && vl[v] && rk[v] > rk[w]) begin
				o[v] = rk[v] - 1'b1;
			end
		end
		o[w] = '0;
		return o;
	endfunction

	function automatic logic [AW-1:0] n_rebuild(input logic [NTW-1:0] t,
		input logic [NSW-1:0] s);
		logic [AW:0] hi, lo;
		hi = (AW+1)'(t) << NSH;
		lo = (AW+1)'(s) << OFFSET_BITS;
		return AW'(hi + lo);
	endfunction

	function automatic logic [AW-1:0] f_rebuild(input logic [FTW-1:0] t,
		input logic [FSW-1:0] s);
		logic [AW:0] hi, lo;
		hi = (AW+1)'(t) << FSH;
		lo = (AW+1)'(s) << OFFSET_BITS;
		return AW'(hi + lo);
	endfunction

	tlict_ram #(.WIDTH(NROW), .DEPTH(NEAR_SETS)) u_near_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (ns_q),
		.rdata (n_rdata)
	);

	tlict_ram #(.WIDTH(FROW), .DEPTH(FAR_SETS)) u_far_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (fs_q),
		.rdata (f_rdata)
	);

	// Row unpack, lookup and victim choice.
	always_comb begin
		for (int w = 0; w < NEAR_WAYS; w++) begin
			nt_r[w] = n_rdata[w*NEW +: NTW];
			nr_r[w] = n_rdata[w*NEW+NTW +: NWW];
			nd_r[w] = n_rdata[w*NEW+NTW+NWW];
			nv_r[w] = n_rdata[w*NEW+NTW+NWW+1];
		end
		for (int w = 0; w < FAR_WAYS; w++) begin
			ft_r[w] = f_rdata[w*FEW +: FTW];
			fr_r[w] = f_rdata[w*FEW+FTW +: FWW];
			fd_r[w] = f_rdata[w*FEW+FTW+FWW];
			fv_r[w] = f_rdata[w*FEW+FTW+FWW+1];
		end
		n_tag = NTW'(jaddr_q >> NSH);
		f_tag = FTW'(jaddr_q >> FSH);
		q     = QW'(jaddr_q >> OFFSET_BITS);

		// first matching way wins
		nhit = 1'b0;
		nway = '0;
		for (int w = NEAR_WAYS - 1; w >= 0; w--) begin
			if (nv_r[w] && nt_r[w] == n_tag) begin
				nhit = 1'b1;
				nway = NWW'(w);
			end
		end
		fhit = 1'b0;
		fway = '0;
		for (int w = FAR_WAYS - 1; w >= 0; w--) begin
			if (fv_r[w] && ft_r[w] == f_tag) begin
				fhit = 1'b1;
				fway = FWW'(w);
			end
		end

		// oldest way, lowest index on ties; first invalid way overrides
		npick = '0;
		for (int w = 1; w < NEAR_WAYS; w++) begin
			if (nr_r[w] > nr_r[npick]) begin
				npick = NWW'(w);
			end
		end
		for (int w = NEAR_WAYS - 1; w >= 0; w--) begin
			if (!nv_r[w]) begin
				npick = NWW'(w);
			end
		end
		fpick = '0;
		for (int w = 1; w < FAR_WAYS; w++) begin
			if (fr_r[w] > fr_r[fpick]) begin
				fpick = FWW'(w);
			end
		end
		for (int w = FAR_WAYS - 1; w >= 0; w--) begin
			if (!fv_r[w]) begin
				fpick = FWW'(w);
			end
		end

		// reciprocal remainder: the quotient from the product is registered, the remainder is formed from it
		n_prod = PW'(q) * PW'(NMUL);
		f_prod = PW'(q) * PW'(FMUL);
		n_rem  = q - nquo_s1 * QW'(NEAR_SETS);
		f_rem  = q - fquo_s1 * QW'(FAR_SETS);
	end

	// Sequencer: next state, row modification and RAM controls.
	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		ret_fill_d  = ret_fill_q;
		clr_d       = clr_q;
		cnt_d       = cnt_q;
		op_d        = op_q;
		eot_d       = eot_q;
		a_d         = a_q;
		jaddr_d     = jaddr_q;
		ns_d        = ns_q;
		fs_d        = fs_q;
		level_d     = level_q;
		wb_d        = wb_q;
		marked_d    = marked_q;
		l2wb_d      = l2wb_q;
		fvict_d     = fvict_q;
		out_valid_d = out_valid_q && !rsp.ready;
		o_level_d   = o_level_q;
		o_wb_d      = o_wb_q;
		o_marked_d  = o_marked_q;
		o_l2wb_d    = o_l2wb_q;
		o_eot_d     = o_eot_q;

		nt_w = nt_r;
		nr_w = nr_r;
		nv_w = nv_r;
		nd_w = nd_r;
		ft_w = ft_r;
		fr_w = fr_r;
		fv_w = fv_r;
		fd_w = fd_r;
		n_we    = 1'b0;
		f_we    = 1'b0;
		n_re    = 1'b0;
		f_re    = 1'b0;
		n_waddr = ns_q;
		f_waddr = fs_q;
		req.ready = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				n_we    = ({1'b0, clr_q} < (CLW+1)'(NEAR_SETS));
				f_we    = ({1'b0, clr_q} < (CLW+1)'(FAR_SETS));
				n_waddr = NSW'(clr_q);
				f_waddr = FSW'(clr_q);
				clr_d   = clr_q + 1'b1;
				if (clr_q == CLW'(MAXS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d     = req.operation;
					eot_d    = req.end_of_trace;
					a_d      = AW'(req.address);
					jaddr_d  = AW'(req.address);
					job_d    = J_LOOK;
					wb_d     = '0;
					marked_d = 1'b0;
					l2wb_d   = 1'b0;
					state_d  = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (POW2) begin
					ns_d    = (NEAR_SETS == 1) ? '0 : NSW'(q);
					fs_d    = (FAR_SETS == 1) ? '0 : FSW'(q);
					state_d = ST_READ;
				end else begin
					if (!cnt_q) begin
						cnt_d = 1'b1;
					end else begin
						ns_d    = NSW'(n_rem);
						fs_d    = FSW'(f_rem);
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				n_re    = 1'b1;
				f_re    = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_SPLIT;
				jaddr_d = a_q;
				unique case (job_q)
					J_LOOK: begin
						if (nhit) begin
							nr_w = n_touch(nr_r, nv_r, nway);
							if (op_q == OP_WRITE) begin
								nd_w[nway] = 1'b1;
							end
							n_we    = 1'b1;
							level_d = HIT_L1;
							state_d = ST_FIN;
						end else if (fhit) begin
							fr_w    = f_touch(fr_r, fv_r, fway);
							f_we    = 1'b1;
							level_d = HIT_L2;
							job_d   = J_NFILL;
						end else begin
							level_d = MISS_BOTH;
							fvict_d = fpick;
							if (fv_r[fpick]) begin
								// inclusion: drop the L1 copy of the L2 victim first
								job_d   = J_NINV;
								jaddr_d = f_rebuild(ft_r[fpick], fs_q);
							end else begin
								job_d = J_FFILL;
							end
						end
					end
					J_NINV: begin
						job_d = J_FFILL;
						if (nhit) begin
							nr_w       = n_close(nr_r, nv_r, nway);
							nv_w[nway] = 1'b0;
							nd_w[nway] = 1'b0;
							n_we       = 1'b1;
							if (nd_r[nway]) begin
								wb_d       = wb_q + 2'd1;
								job_d      = J_FMARK;
								ret_fill_d = 1'b1;
								jaddr_d    = n_rebuild(nt_r[nway], ns_q);
							end
						end
					end
					J_FMARK: begin
						if (fhit) begin
							fd_w[fway] = 1'b1;
							fr_w       = f_touch(fr_r, fv_r, fway);
							f_we       = 1'b1;
						end
						if (ret_fill_q) begin
							job_d = J_FFILL;
						end else begin
							state_d = ST_FIN;
						end
					end
					J_FFILL: begin
						// victim dirt is sampled here, after the L1 write-back may have marked it
						l2wb_d        = fv_r[fvict_q] && fd_r[fvict_q];
						fr_w          = f_touch(fr_r, fv_r, fvict_q);
						ft_w[fvict_q] = f_tag;
						fv_w[fvict_q] = 1'b1;
						fd_w[fvict_q] = 1'b0;
						f_we          = 1'b1;
						job_d         = J_NFILL;
					end
					J_NFILL: begin
						nr_w        = n_touch(nr_r, nv_r, npick);
						nt_w[npick] = n_tag;
						nv_w[npick] = 1'b1;
						nd_w[npick] = (op_q == OP_WRITE);
						n_we        = 1'b1;
						state_d     = ST_FIN;
						if (nv_r[npick] && nd_r[npick]) begin
							// dirty L1 victim goes back into its L2 line
							wb_d       = wb_q + 2'd1;
							marked_d   = 1'b1;
							job_d      = J_FMARK;
							ret_fill_d = 1'b0;
							jaddr_d    = n_rebuild(nt_r[npick], ns_q);
							state_d    = ST_SPLIT;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					o_level_d   = level_q;
					o_wb_d      = wb_q;
					o_marked_d  = marked_q;
					o_l2wb_d    = l2wb_q;
					o_eot_d     = eot_q;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// every entry into a split pass restarts the remainder unit
		if (state_d == ST_SPLIT && state_q != ST_SPLIT) begin
			cnt_d = 1'b0;
		end

		for (int w = 0; w < NEAR_WAYS; w++) begin
			n_wdata[w*NEW +: NEW] = (state_q == ST_CLEAR) ? '0 :
				{nv_w[w], nd_w[w], nr_w[w], nt_w[w]};
		end
		for (int w = 0; w < FAR_WAYS; w++) begin
			f_wdata[w*FEW +: FEW] = (state_q == ST_CLEAR) ? '0 :
				{fv_w[w], fd_w[w], fr_w[w], ft_w[w]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			job_q       <= J_LOOK;
			ret_fill_q  <= 1'b0;
			clr_q       <= '0;
			cnt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			job_q       <= job_d;
			ret_fill_q  <= ret_fill_d;
			clr_q       <= clr_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		eot_q      <= eot_d;
		a_q        <= a_d;
		jaddr_q    <= jaddr_d;
		nquo_s1    <= QW'(n_prod >> (QW + NL));
		fquo_s1    <= QW'(f_prod >> (QW + FL));
		ns_q       <= ns_d;
		fs_q       <= fs_d;
		level_q    <= level_d;
		wb_q       <= wb_d;
		marked_q   <= marked_d;
		l2wb_q     <= l2wb_d;
		fvict_q    <= fvict_d;
		o_level_q  <= o_level_d;
		o_wb_q     <= o_wb_d;
		o_marked_q <= o_marked_d;
		o_l2wb_q   <= o_l2wb_d;
		o_eot_q    <= o_eot_d;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hit_level       = o_level_q;
	assign rsp.l1_writebacks   = o_wb_q;
	assign rsp.l2_marked_dirty = o_marked_q;
	assign rsp.l2_writeback    = o_l2wb_q;
	assign rsp.trace_done      = o_eot_q;

	// no request is taken while the RAMs are being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !req.ready)
		else $error("request accepted during clearing pass");

	// an L1 victim write-back is always counted
	a_marked_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.l2_marked_dirty |-> rsp.l1_writebacks != 2'd0)
		else $error("L2 marked dirty without L1 write-back");

	// an L1 hit never replaces anything
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit_level == HIT_L1 |->
		rsp.l1_writebacks == 2'd0 && !rsp.l2_writeback)
		else $error("L1 hit reported a write-back");

	// L2 replacement only happens on a miss in both levels
	a_l2wb_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.l2_writeback |-> rsp.hit_level == MISS_BOTH)
		else $error("L2 write-back without a miss in both levels");

endmodule

### tb/tlict_scoreboard.sv
`timescale 1ns / 100ps
// Checker: predicts the outcome of each cache access and compares responses.
module tlict_scoreboard
	import tlict_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tlict_req_if.sink   req_mon,
	tlict_rsp_if.sink   rsp_mon,
	output int          fail_count,
	output int          pending,
	output int          accepted_rsp
);
	localparam int OFS = 6;
	localparam int NSETS = 64, NWAYS = 4, NLG = 6;
	localparam int FSETS = 512, FWAYS = 8, FLG = 9;

	typedef struct packed {
		logic [1:0] hit_level;
		logic [1:0] l1_writebacks;
		logic       l2_marked_dirty;
		logic       l2_writeback;
		logic       trace_done;
	} outcome_t;

	logic [31:0] n_tag [NSETS*NWAYS];
	logic        n_val [NSETS*NWAYS];
	logic        n_dty [NSETS*NWAYS];
	int          n_rnk [NSETS*NWAYS];
	logic [31:0] f_tag [FSETS*FWAYS];
	logic        f_val [FSETS*FWAYS];
	logic        f_dty [FSETS*FWAYS];
	int          f_rnk [FSETS*FWAYS];

	outcome_t outcome_q[$];

	task automatic report(input string what);
		fail_count++;
		$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	// Move a way to rank 0, aging valid lines that were more recent.
	task automatic promote(input bit far, input int base, input int ways, input int w);
		int old;
		if (far) begin
			old = f_val[base+w] ? f_rnk[base+w] : ways;
			for (int v = 0; v < ways; v++)
				if (v != w && f_val[base+v] && f_rnk[base+v] < old) f_rnk[base+v]++;
			f_rnk[base+w] = 0;
		end else begin
			old = n_val[base+w] ? n_rnk[base+w] : ways;
			for (int v = 0; v < ways; v++)
				if (v != w && n_val[base+v] && n_rnk[base+v] < old) n_rnk[base+v]++;
			n_rnk[base+w] = 0;
		end
	endtask

	function automatic int victim(input bit far, input int base, input int ways);
		int best;
		best = 0;
		for (int i = 0; i < ways; i++) begin
			if (far ? !f_val[base+i] : !n_val[base+i]) return i;
			if (far ? f_rnk[base+i] > f_rnk[base+best] : n_rnk[base+i] > n_rnk[base+best])
				best = i;
		end
		return best;
	endfunction

	function automatic int lookup(input bit far, input int base, input int ways,
		input logic [31:0] tag);
		for (int i = 0; i < ways; i++)
			if (far ? (f_val[base+i] && f_tag[base+i] == tag)
				: (n_val[base+i] && n_tag[base+i] == tag)) return i;
		return -1;
	endfunction

	task automatic far_mark(input logic [31:0] a);
		int base, w;
		base = ((a >> OFS) % FSETS) * FWAYS;
		w = lookup(1, base, FWAYS, a >> (OFS + FLG));
		if (w >= 0) begin
			f_dty[base+w] = 1;
			promote(1, base, FWAYS, w);
		end
	endtask

	task automatic near_drop(input logic [31:0] a, inout int wb);
		int set, base, w, r;
		set = (a >> OFS) % NSETS;
		base = set * NWAYS;
		w = lookup(0, base, NWAYS, a >> (OFS + NLG));
		if (w < 0) return;
		r = n_rnk[base+w];
		for (int v = 0; v < NWAYS; v++)
			if (v != w && n_val[base+v] && n_rnk[base+v] > r) n_rnk[base+v]--;
		n_rnk[base+w] = 0;
		n_val[base+w] = 0;
		if (n_dty[base+w]) begin
			wb++;
			far_mark((n_tag[base+w] << (OFS + NLG)) + (set << OFS));
		end
		n_dty[base+w] = 0;
	endtask

	task automatic near_alloc(input logic [31:0] a, inout int wb, inout int marked,
		output int line);
		int set, base, v;
		set = (a >> OFS) % NSETS;
		base = set * NWAYS;
		v = victim(0, base, NWAYS);
		if (n_val[base+v] && n_dty[base+v]) begin
			wb++;
			marked = 1;
			far_mark((n_tag[base+v] << (OFS + NLG)) + (set << OFS));
		end
		promote(0, base, NWAYS, v);
		n_tag[base+v] = a >> (OFS + NLG);
		n_val[base+v] = 1;
		n_dty[base+v] = 0;
		line = base + v;
	endtask

	task automatic far_alloc(input logic [31:0] a, inout int wb, inout int l2wb);
		int set, base, v;
		set = (a >> OFS) % FSETS;
		base = set * FWAYS;
		v = victim(1, base, FWAYS);
		if (f_val[base+v]) begin
			near_drop((f_tag[base+v] << (OFS + FLG)) + (set << OFS), wb);
			if (f_dty[base+v]) l2wb = 1;
		end
		promote(1, base, FWAYS, v);
		f_tag[base+v] = a >> (OFS + FLG);
		f_val[base+v] = 1;
		f_dty[base+v] = 0;
	endtask

	task automatic predict_access(input logic op, input logic [31:0] a, input logic eot);
		int nbase, fbase, w, line, wb, marked, l2wb;
		outcome_t o;
		wb = 0; marked = 0; l2wb = 0;
		nbase = ((a >> OFS) % NSETS) * NWAYS;
		fbase = ((a >> OFS) % FSETS) * FWAYS;
		w = lookup(0, nbase, NWAYS, a >> (OFS + NLG));
		if (w >= 0) begin
			o.hit_level = HIT_L1;
			promote(0, nbase, NWAYS, w);
			line = nbase + w;
		end else begin
			w = lookup(1, fbase, FWAYS, a >> (OFS + FLG));
			if (w >= 0) begin
				o.hit_level = HIT_L2;
				promote(1, fbase, FWAYS, w);
			end else begin
				o.hit_level = MISS_BOTH;
				far_alloc(a, wb, l2wb);
			end
			near_alloc(a, wb, marked, line);
		end
		if (op == OP_WRITE) n_dty[line] = 1;
		o.l1_writebacks = wb[1:0];
		o.l2_marked_dirty = marked[0];
		o.l2_writeback = l2wb[0];
		o.trace_done = eot;
		outcome_q = {outcome_q, o};
	endtask

	initial begin
		fail_count = 0;
		accepted_rsp = 0;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			n_tag[i] = '0; n_val[i] = 0; n_dty[i] = 0; n_rnk[i] = 0;
		end
		for (int i = 0; i < FSETS*FWAYS; i++) begin
			f_tag[i] = '0; f_val[i] = 0; f_dty[i] = 0; f_rnk[i] = 0;
		end
	end

	assign pending = outcome_q.size();

	always @(posedge clk) begin
		outcome_t exp_o, got;
		if (arst_n) begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				accepted_rsp++;
				got = '{rsp_mon.hit_level, rsp_mon.l1_writebacks, rsp_mon.l2_marked_dirty,
					rsp_mon.l2_writeback, rsp_mon.trace_done};
				if (outcome_q.size() == 0) begin
					report("response with no access outstanding");
				end else begin
					exp_o = outcome_q.pop_front();
					if (got.hit_level != exp_o.hit_level)
						report($sformatf("hit_level %0d, want %0d", got.hit_level,
							exp_o.hit_level));
					if (got.l1_writebacks != exp_o.l1_writebacks)
						report($sformatf("l1_writebacks %0d, want %0d", got.l1_writebacks,
							exp_o.l1_writebacks));
					if (got.l2_marked_dirty != exp_o.l2_marked_dirty)
						report($sformatf("l2_marked_dirty %0d, want %0d",
							got.l2_marked_dirty, exp_o.l2_marked_dirty));
					if (got.l2_writeback != exp_o.l2_writeback)
						report($sformatf("l2_writeback %0d, want %0d", got.l2_writeback,
							exp_o.l2_writeback));
					if (got.trace_done != exp_o.trace_done)
						report($sformatf("trace_done %0d, want %0d", got.trace_done,
							exp_o.trace_done));
				end
			end
			// Predict after the response check so a same-edge request cannot be popped early.
			if (req_mon.valid && req_mon.ready)
				predict_access(req_mon.operation, req_mon.address, req_mon.end_of_trace);
		end
	end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the cache tag testbench: stimulus, response stalls and the verdict.
module tb;
	import tlict_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000; // covers the clearing pass too

	logic clk;
	logic arst_n;
	int   fail_count, pending, accepted_rsp;
	int   idle_cycles;
	int   requests_sent, writes_sent;
	bit   calm;   // no idling in the last part of the run

	tlict_req_if req ();
	tlict_rsp_if rsp ();

	two_level_inclusive_cache_tags dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	tlict_scoreboard chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_mon     (req.sink),
		.rsp_mon     (rsp.sink),
		.fail_count  (fail_count),
		.pending     (pending),
		.accepted_rsp(accepted_rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Response side: ready drops for random stretches while not calm.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog: cycles in which no request and no response is accepted.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d responses outstanding", pending);
			$display("two_level_inclusive_cache_tags regression: fail");
			$finish;
		end
	end

	// One request, held until accepted; optional gap before it.
	task automatic send_access(input logic op, input logic [31:0] a, input logic eot);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.operation    <= op;
		req.address      <= a;
		req.end_of_trace <= eot;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		requests_sent++;
		if (op == OP_WRITE) writes_sent++;
	endtask

	// Address in one of a few hot far sets, so ways fill up and evictions happen.
	function automatic logic [31:0] hot_address(input int hot_sets);
		logic [31:0] a;
		a = $urandom();
		a[14:6] = 9'($urandom_range(0, hot_sets - 1)) * 9'd37;
		a[5:0] = 6'($urandom());
		// Small tag pool so blocks get reused.
		a[31:15] = 17'($urandom_range(0, 12)) ^ (a[31] ? 17'h1ffff : 17'h0);
		return a;
	endfunction

	initial begin
		logic [31:0] a;
		idle_cycles = 0;
		requests_sent = 0;
		writes_sent = 0;
		calm = 0;
		req.valid = 1'b0;
		req.operation = 1'b0;
		req.address = '0;
		req.end_of_trace = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of address, both ops, end of trace.
		send_access(1'b0, 32'h0000_0000, 1'b0);
		send_access(1'b1, 32'h0000_0000, 1'b0);    // L1 hit, write makes dirty
		send_access(1'b1, 32'hFFFF_FFFF, 1'b1);
		send_access(1'b0, 32'hFFFF_FFC0, 1'b0);    // same line, L1 hit
		// Fill one near set past its four ways with dirty lines: dirty L1 evictions.
		for (int i = 1; i <= 6; i++)
			send_access(1'b1, 32'(i) << 12, 1'b0);
		// Re-read an evicted block: L1 miss, L2 hit.
		send_access(1'b0, 32'h0000_1000, 1'b0);
		// Overflow one far set (8 ways) with dirty blocks: L2 dirty write-back
		// and invalidation of the L1 copy.
		for (int i = 1; i <= 10; i++)
			send_access(1'b1, (32'(i) << 15) | 32'h40, i == 10);
		send_access(1'b0, 32'h0000_8040, 1'b0);

		// Pause until every response has come back.
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random: mostly hot-set traffic, some fully random noise.
		for (int n = 0; n < 1200; n++) begin
			if (n == 1000) calm = 1;
			if ($urandom_range(0, 9) == 0) a = $urandom();
			else a = hot_address(n < 600 ? 4 : 16);
			send_access(1'($urandom()), a, $urandom_range(0, 49) == 0);
		end
		req.valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d accesses (%0d writes), %0d responses checked",
			requests_sent, writes_sent, accepted_rsp);
		if (fail_count == 0) begin
			$display("two_level_inclusive_cache_tags regression: pass");
		end else begin
			$display("two_level_inclusive_cache_tags regression: fail");
		end
		$finish;
	end
endmodule
